// File: rtl/lspli_pkg.sv
// package: types, constants and the rate table of the looping sample player
package lspli_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int FRAC_BITS   = 16;

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int PHASE_W = ADDR_W + FRAC_BITS;
  localparam int RATE_W  = FRAC_BITS + 2;
  localparam int SAMP_W  = 16;
  localparam int LEN_W   = 13;
  localparam int STEP_W  = 24;
  localparam int CTL_W   = 8;
  localparam int IDX_W   = 12;
  localparam int DATA_W  = 24;
  localparam int MUL_W   = RATE_W + STEP_W;
  localparam int ACC_W   = SAMP_W + FRAC_BITS + 2;
  localparam int NUM_W   = ADDR_W + 1;
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int SPAN_W  = ADDR_W + 1;

  localparam int OUT_MAX        = 32767;
  localparam int LEN_RESET      = 4096;
  localparam int STEP_RESET     = 1558265;
  localparam int CTL_DIRECT_MIN = 64;
  localparam int RATE_TAB_LAST  = 64;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_RATE   = 2'd1,
    REQ_RENDER = 2'd2
  } req_type_e;

  typedef enum logic [0:0] {
    CFG_LOOP_LENGTH = 1'b0,
    CFG_STEP_SCALE  = 1'b1
  } cfg_idx_e;

  typedef logic [RATE_W-1:0] rate_tab_t [0:RATE_TAB_LAST];

  // rate (63+v)/127 for v in 0..64, rounded half up
  function automatic rate_tab_t build_rate_tab();
    rate_tab_t t;
    longint    num;
    for (int i = 0; i <= RATE_TAB_LAST; i++) begin
      num  = (longint'(63 + i) <<< FRAC_BITS) + 63;
      t[i] = RATE_W'(num / 127);
    end
    return t;
  endfunction

  localparam rate_tab_t RATE_TAB = build_rate_tab();

endpackage

// File: rtl/looping_sample_player_linear_interp.sv
// top level: looping sample player with linear interpolation
//
// An item is taken at a clock edge with start_i high and busy_o low. req_type_i
// selects a table load (table_index_i, table_value_i), a rate update from
// control_value_i, or a render. Only a render gives a result: audio_out_o is
// valid for one cycle with done_o high, after the table read, the accumulator
// and the output register; the receiver cannot stall, so the result is simply
// presented once. Items may be given every cycle while busy_o is low. After a
// rate update or a register write, busy_o is high for one cycle while the phase
// step product is registered. When a render wraps the phase by more than one
// loop length, the wrap is done by a bit-serial remainder unit and busy_o stays
// high until done; the result pipeline runs on meanwhile. The user must write
// the register port (cfg_we_i, cfg_index_i, cfg_data_i) only while idle; the
// block does not enforce it. Reset sets phase to zero, rate to one, loop_length
// to 4096 and step_scale to its default, and holds busy_o high for one cycle.
// The table has no reset and no clearing pass: load words before playing them.
module looping_sample_player_linear_interp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         req_type_i,
  input  logic [lspli_pkg::IDX_W-1:0]        table_index_i,
  input  logic signed [lspli_pkg::SAMP_W-1:0] table_value_i,
  input  logic signed [lspli_pkg::CTL_W-1:0] control_value_i,
  input  logic                               cfg_we_i,
  input  logic [0:0]                         cfg_index_i,
  input  logic [lspli_pkg::DATA_W-1:0]       cfg_data_i,
  output logic signed [lspli_pkg::SAMP_W-1:0] audio_out_o,
  output logic                               done_o
);

  localparam int ADDR_W  = lspli_pkg::ADDR_W;
  localparam int FRAC    = lspli_pkg::FRAC_BITS;
  localparam int PHASE_W = lspli_pkg::PHASE_W;
  localparam int RATE_W  = lspli_pkg::RATE_W;
  localparam int SAMP_W  = lspli_pkg::SAMP_W;
  localparam int ACC_W   = lspli_pkg::ACC_W;
  localparam int NUM_W   = lspli_pkg::NUM_W;
  localparam int CNT_W   = lspli_pkg::CNT_W;
  localparam int SPAN_W  = lspli_pkg::SPAN_W;
  localparam int MUL_W   = lspli_pkg::MUL_W;
  localparam int LEN_W   = lspli_pkg::LEN_W;
  localparam int STEP_W  = lspli_pkg::STEP_W;

  // registers
  logic [LEN_W-1:0]   loop_length_q, loop_length_d;
  logic [STEP_W-1:0]  step_scale_q, step_scale_d;
  logic [RATE_W-1:0]  rate_q, rate_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [RATE_W-1:0]  inc_q;
  logic               hold_q, hold_d;
  logic               red_active_q, red_active_d;
  logic [CNT_W-1:0]   red_cnt_q, red_cnt_d;
  logic [NUM_W-1:0]   red_num_q, red_num_d;
  logic [ADDR_W-1:0]  red_rem_q, red_rem_d;
  logic               s1_valid_q;
  logic [FRAC-1:0]    b_q;
  logic               s2_valid_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic               done_q;
  logic signed [SAMP_W-1:0] audio_out_q, audio_out_d;

  logic accept;
  logic do_load, do_rate, do_render;
  logic [SPAN_W-1:0]  span;
  logic [ADDR_W-1:0]  div;
  logic [PHASE_W:0]   limit;
  logic [PHASE_W:0]   sum;
  logic [PHASE_W:0]   diff;
  logic [NUM_W-1:0]   rem_sh;
  logic [NUM_W-1:0]   rem_nx;
  logic [MUL_W-1:0]   inc_prod;
  logic [ADDR_W-1:0]  raddr_a, raddr_b;
  logic [SAMP_W-1:0]  rdata_a, rdata_b;
  logic signed [SAMP_W:0]  dlt;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] biased;
  logic signed [ACC_W-1:0] y;

  assign accept = start_i && !busy_o;
  assign busy_o = hold_q || red_active_q;

  always_comb begin
    do_load   = 1'b0;
    do_rate   = 1'b0;
    do_render = 1'b0;
    unique case (lspli_pkg::req_type_e'(req_type_i))
      lspli_pkg::REQ_LOAD:   do_load   = accept;
      lspli_pkg::REQ_RATE:   do_rate   = accept;
      lspli_pkg::REQ_RENDER: do_render = accept;
      default: ;
    endcase
  end

  // sample table
  assign raddr_a = phase_q[PHASE_W-1:FRAC];
  assign raddr_b = raddr_a + ADDR_W'(1);

  lspli_ram #(
    .WIDTH(SAMP_W),
    .DEPTH(lspli_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (do_load),
    .waddr_i   (table_index_i[ADDR_W-1:0]),
    .wdata_i   (table_value_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // configuration
  always_comb begin
    loop_length_d = loop_length_q;
    step_scale_d  = step_scale_q;
    if (cfg_we_i) begin
      unique case (lspli_pkg::cfg_idx_e'(cfg_index_i))
        lspli_pkg::CFG_LOOP_LENGTH: loop_length_d = cfg_data_i[LEN_W-1:0];
        lspli_pkg::CFG_STEP_SCALE:  step_scale_d  = cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // rate from control value
  always_comb begin
    rate_d = rate_q;
    if (do_rate) begin
      priority if (control_value_i > lspli_pkg::CTL_W'(lspli_pkg::CTL_DIRECT_MIN)) begin
        rate_d = RATE_W'(control_value_i[lspli_pkg::CTL_W-2:0]) << (FRAC - 6);
      end else if (!control_value_i[lspli_pkg::CTL_W-1]) begin
        rate_d = lspli_pkg::RATE_TAB[control_value_i[lspli_pkg::CTL_W-2:0]];
      end else begin
        rate_d = rate_q;
      end
    end
  end

  assign inc_prod = MUL_W'(rate_q) * MUL_W'(step_scale_q);

  // loop span and wrap limit
  always_comb begin
    priority if (loop_length_q < LEN_W'(2)) begin
      span = SPAN_W'(2);
    end else if (32'(loop_length_q) > lspli_pkg::TABLE_DEPTH) begin
      span = SPAN_W'(lspli_pkg::TABLE_DEPTH);
    end else begin
      span = SPAN_W'(loop_length_q);
    end
  end

  assign div   = ADDR_W'(span - SPAN_W'(1));
  assign limit = {1'b0, div, {FRAC{1'b0}}};
  assign sum   = {1'b0, phase_q} + (PHASE_W + 1)'(inc_q);
  assign diff  = sum - limit;

  // bit-serial remainder of the whole-sample part
  assign rem_sh = {red_rem_q, red_num_q[NUM_W-1]};
  assign rem_nx = (rem_sh >= {1'b0, div}) ? rem_sh - {1'b0, div} : rem_sh;

  // phase and control flags
  always_comb begin
    phase_d      = phase_q;
    hold_d       = do_rate || cfg_we_i;
    red_active_d = red_active_q;
    red_cnt_d    = red_cnt_q;
    red_num_d    = red_num_q;
    red_rem_d    = red_rem_q;
    if (red_active_q) begin
      red_num_d = red_num_q << 1;
      red_rem_d = rem_nx[ADDR_W-1:0];
      red_cnt_d = red_cnt_q - CNT_W'(1);
      if (red_cnt_q == '0) begin
        red_active_d              = 1'b0;
        phase_d[PHASE_W-1:FRAC] = rem_nx[ADDR_W-1:0];
      end
    end else if (do_render) begin
      priority if (sum < limit) begin
        phase_d = sum[PHASE_W-1:0];
      end else if (diff < limit) begin
        phase_d = diff[PHASE_W-1:0];
      end else begin
        phase_d[FRAC-1:0] = sum[FRAC-1:0];
        red_active_d      = 1'b1;
        red_cnt_d         = CNT_W'(NUM_W - 1);
        red_num_d         = sum[PHASE_W:FRAC];
        red_rem_d         = '0;
      end
    end
  end

  // interpolation and clipping
  assign dlt  = {rdata_b[SAMP_W-1], rdata_b} - {rdata_a[SAMP_W-1], rdata_a};
  assign prod = ACC_W'($signed({1'b0, b_q})) * ACC_W'(dlt);

  always_comb begin
    acc_d  = (ACC_W'($signed(rdata_a)) <<< FRAC) + prod;
    biased = acc_q + (acc_q[ACC_W-1] ? ACC_W'((1 << FRAC) - 1) : ACC_W'(0));
    y      = biased >>> FRAC;
    priority if (y > ACC_W'(lspli_pkg::OUT_MAX)) begin
      audio_out_d = SAMP_W'(lspli_pkg::OUT_MAX);
    end else if (y < ACC_W'(-lspli_pkg::OUT_MAX)) begin
      audio_out_d = SAMP_W'(-lspli_pkg::OUT_MAX);
    end else begin
      audio_out_d = y[SAMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_length_q <= LEN_W'(lspli_pkg::LEN_RESET);
      step_scale_q  <= STEP_W'(lspli_pkg::STEP_RESET);
      rate_q        <= RATE_W'(1) << FRAC;
      phase_q       <= '0;
      hold_q        <= 1'b1;
      red_active_q  <= 1'b0;
      red_cnt_q     <= '0;
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      loop_length_q <= loop_length_d;
      step_scale_q  <= step_scale_d;
      rate_q        <= rate_d;
      phase_q       <= phase_d;
      hold_q        <= hold_d;
      red_active_q  <= red_active_d;
      red_cnt_q     <= red_cnt_d;
      s1_valid_q    <= do_render;
      s2_valid_q    <= s1_valid_q;
      done_q        <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    inc_q       <= inc_prod[STEP_W +: RATE_W];
    red_num_q   <= red_num_d;
    red_rem_q   <= red_rem_d;
    b_q         <= phase_q[FRAC-1:0];
    acc_q       <= acc_d;
    audio_out_q <= audio_out_d;
  end

  assign audio_out_o = audio_out_q;
  assign done_o      = done_q;

  // checks
  a_rate_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_rate |=> busy_o)
    else $error("no hold cycle after a rate update");

  a_wrap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(red_active_q) |-> (phase_q[PHASE_W-1:FRAC] < div))
    else $error("phase outside the loop after wrap");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(do_render, 3))
    else $error("result without a render transfer three cycles earlier");

  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (audio_out_o != {1'b1, {(SAMP_W - 1){1'b0}}}))
    else $error("output not clipped");

endmodule

// File: rtl/lspli_ram.sv
// generic ram: one write port, two registered read ports
module lspli_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [0:DEPTH-1];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
